// File: sv/jtkv_pkg.sv
package jtkv_pkg;

  localparam int unsigned MAX_NODES = 4096;
  localparam int unsigned FANOUT    = 11;
  localparam int unsigned NODE_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned SLOT_W    = $clog2(FANOUT);
  localparam int unsigned KEY_ID_W  = 12;

  localparam logic [1:0] REQ_LOAD_CHAR = 2'd0;
  localparam logic [1:0] REQ_LOAD_END  = 2'd1;
  localparam logic [1:0] REQ_SCAN      = 2'd2;

  localparam logic [1:0] KIND_KEY_MATCH = 2'd0;
  localparam logic [1:0] KIND_VALUE     = 2'd1;
  localparam logic [1:0] KIND_VALUE_END = 2'd2;
  localparam logic [1:0] KIND_LOAD_FAIL = 2'd3;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [SLOT_W-1:0] SLOT_MINUS = SLOT_W'(10);

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          result_kind;
    logic [KEY_ID_W-1:0] key_id;
    logic [7:0]          value_byte;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic                           mark;
    logic [FANOUT-1:0][NODE_W-1:0]  child;
  } node_row_t;

endpackage

// File: sv/jtkv_ram.sv
module jtkv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: sv/json_trie_key_value_extractor.sv
// Loads digit and minus keys into a trie held in one node memory, one row per node with
// eleven child pointers and an end mark, then scans a JSON byte stream and reports each
// matched key, its value bytes and a value-finished item, or a load-failure item for a
// key that overflows. For each input item the row of the current node is read from the
// single node memory, then modified and written back; no new item is taken before the
// write-back, which waits while a result meets an untaken one in the output register.
// After reset the node memory is cleared one row a cycle; no item is accepted until the pass is done.
module json_trie_key_value_extractor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  jtkv_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output jtkv_pkg::out_item_t out_item_o
);

  typedef enum logic [2:0] {
    PH_SEEK_QUOTE,
    PH_KEY,
    PH_SEEK_COLON,
    PH_VALUE_START,
    PH_IN_QUOTES,
    PH_UNQUOTED
  } phase_e;

  localparam int unsigned ROW_W = $bits(jtkv_pkg::node_row_t);
  localparam int unsigned NW    = jtkv_pkg::NODE_W;

  logic                  clr_q;
  logic [NW-1:0]         clr_cnt_q;
  logic                  busy_q;
  logic [1:0]            b_req_q;
  logic [7:0]            b_byte_q;
  logic [NW:0]           nodes_used_q, nodes_used_d;
  logic [NW-1:0]         load_cursor_q, load_cursor_d;
  logic                  load_ovf_q, load_ovf_d;
  phase_e                phase_q, phase_d;
  logic [NW-1:0]         scan_node_q, scan_node_d;
  logic                  matching_q, matching_d;
  logic                  out_valid_q;
  jtkv_pkg::out_item_t   out_q;

  jtkv_pkg::node_row_t   rd_row, mod_row;
  logic [ROW_W-1:0]      rd_data, wr_data;
  logic                  mod_we, ram_we, ram_re, accept, fire, res_valid;
  logic [NW-1:0]         ram_waddr, ram_raddr;
  jtkv_pkg::out_item_t   res;
  logic                  slot_ok;
  logic [jtkv_pkg::SLOT_W-1:0] slot;
  logic [NW-1:0]         child;

  function automatic logic is_ws(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
  endfunction

  assign in_ready_o = !clr_q && !busy_q;
  assign accept     = in_valid_i && in_ready_o;
  assign ram_re     = accept;
  assign ram_raddr  = (in_item_i.req_type == jtkv_pkg::REQ_SCAN) ? scan_node_q : load_cursor_q;
  assign rd_row     = jtkv_pkg::node_row_t'(rd_data);

  assign fire      = busy_q && (!res_valid || !out_valid_q || out_ready_i);
  assign ram_we    = clr_q || (fire && mod_we);
  assign ram_waddr = clr_q ? clr_cnt_q : ((b_req_q == jtkv_pkg::REQ_SCAN) ? scan_node_q
                                                                           : load_cursor_q);
  assign wr_data   = clr_q ? '0 : ROW_W'(mod_row);

  jtkv_ram #(
    .WIDTH (ROW_W),
    .DEPTH (jtkv_pkg::MAX_NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  always_comb begin
    slot_ok = (b_byte_q >= jtkv_pkg::CH_ZERO && b_byte_q <= jtkv_pkg::CH_NINE) ||
              (b_byte_q == jtkv_pkg::CH_MINUS);
    if (b_byte_q == jtkv_pkg::CH_MINUS) begin
      slot = jtkv_pkg::SLOT_MINUS;
    end else if (slot_ok) begin
      slot = jtkv_pkg::SLOT_W'(b_byte_q - jtkv_pkg::CH_ZERO);
    end else begin
      slot = '0;
    end
    child = slot_ok ? rd_row.child[slot] : '0;

    nodes_used_d  = nodes_used_q;
    load_cursor_d = load_cursor_q;
    load_ovf_d    = load_ovf_q;
    phase_d       = phase_q;
    scan_node_d   = scan_node_q;
    matching_d    = matching_q;
    mod_row       = rd_row;
    mod_we        = 1'b0;
    res_valid     = 1'b0;
    res           = '0;

    case (b_req_q)
      jtkv_pkg::REQ_LOAD_CHAR: begin
        if (slot_ok && !load_ovf_q) begin
          if (child == '0) begin
            if (nodes_used_q >= (NW + 1)'(jtkv_pkg::MAX_NODES)) begin
              load_ovf_d = 1'b1;
            end else begin
              mod_row.child[slot] = nodes_used_q[NW-1:0];
              mod_we              = 1'b1;
              nodes_used_d        = nodes_used_q + 1'b1;
              load_cursor_d       = nodes_used_q[NW-1:0];
            end
          end else begin
            load_cursor_d = child;
          end
        end
      end
      jtkv_pkg::REQ_LOAD_END: begin
        load_cursor_d = '0;
        load_ovf_d    = 1'b0;
        if (load_ovf_q) begin
          res_valid       = 1'b1;
          res.result_kind = jtkv_pkg::KIND_LOAD_FAIL;
        end else begin
          mod_row.mark = 1'b1;
          mod_we       = 1'b1;
        end
      end
      jtkv_pkg::REQ_SCAN: begin
        res.key_id = jtkv_pkg::KEY_ID_W'(scan_node_q);
        case (phase_q)
          PH_SEEK_QUOTE: begin
            if (b_byte_q == jtkv_pkg::CH_QUOTE) begin
              phase_d     = PH_KEY;
              scan_node_d = '0;
              matching_d  = 1'b1;
            end
          end
          PH_KEY: begin
            if (b_byte_q == jtkv_pkg::CH_QUOTE) begin
              if (matching_q && rd_row.mark) begin
                phase_d         = PH_SEEK_COLON;
                res_valid       = 1'b1;
                res.result_kind = jtkv_pkg::KIND_KEY_MATCH;
              end else begin
                phase_d = PH_SEEK_QUOTE;
              end
            end else if (matching_q) begin
              if (child != '0) begin
                scan_node_d = child;
              end else begin
                matching_d = 1'b0;
              end
            end
          end
          PH_SEEK_COLON: begin
            if (b_byte_q == jtkv_pkg::CH_COLON) begin
              phase_d = PH_VALUE_START;
            end
          end
          PH_VALUE_START: begin
            if (b_byte_q == jtkv_pkg::CH_QUOTE) begin
              phase_d = PH_IN_QUOTES;
            end else if (!is_ws(b_byte_q)) begin
              phase_d         = PH_UNQUOTED;
              res_valid       = 1'b1;
              res.result_kind = jtkv_pkg::KIND_VALUE;
              res.value_byte  = b_byte_q;
            end
          end
          PH_IN_QUOTES: begin
            res_valid = 1'b1;
            if (b_byte_q == jtkv_pkg::CH_QUOTE) begin
              phase_d         = PH_SEEK_QUOTE;
              res.result_kind = jtkv_pkg::KIND_VALUE_END;
              res.last        = 1'b1;
            end else begin
              res.result_kind = jtkv_pkg::KIND_VALUE;
              res.value_byte  = b_byte_q;
            end
          end
          PH_UNQUOTED: begin
            res_valid = 1'b1;
            if (b_byte_q == jtkv_pkg::CH_COMMA || b_byte_q == jtkv_pkg::CH_RBRACE ||
                is_ws(b_byte_q)) begin
              phase_d         = PH_SEEK_QUOTE;
              res.result_kind = jtkv_pkg::KIND_VALUE_END;
              res.last        = 1'b1;
            end else begin
              res.result_kind = jtkv_pkg::KIND_VALUE;
              res.value_byte  = b_byte_q;
            end
          end
          default: begin
            phase_d = PH_SEEK_QUOTE;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q         <= 1'b1;
      clr_cnt_q     <= '0;
      busy_q        <= 1'b0;
      b_req_q       <= '0;
      b_byte_q      <= '0;
      nodes_used_q  <= (NW + 1)'(1);
      load_cursor_q <= '0;
      load_ovf_q    <= 1'b0;
      phase_q       <= PH_SEEK_QUOTE;
      scan_node_q   <= '0;
      matching_q    <= 1'b1;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == NW'(jtkv_pkg::MAX_NODES - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (accept) begin
        busy_q   <= 1'b1;
        b_req_q  <= in_item_i.req_type;
        b_byte_q <= in_item_i.in_byte;
      end else if (fire) begin
        busy_q <= 1'b0;
      end
      if (fire) begin
        nodes_used_q  <= nodes_used_d;
        load_cursor_q <= load_cursor_d;
        load_ovf_q    <= load_ovf_d;
        phase_q       <= phase_d;
        scan_node_q   <= scan_node_d;
        matching_q    <= matching_d;
      end
      if (fire && res_valid) begin
        out_valid_q <= 1'b1;
        out_q       <= res;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: sv/jtkv_checker.sv
module jtkv_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input jtkv_pkg::out_item_t out_item_o
);

  // A held result item must not change until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  // No item is accepted while an accepted one still occupies the node memory.
  a_two_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted in consecutive cycles");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.last == (out_item_o.result_kind == jtkv_pkg::KIND_VALUE_END)))
    else $error("last flag does not match value-finished kind");

  a_fail_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.result_kind == jtkv_pkg::KIND_LOAD_FAIL |->
      out_item_o.key_id == '0 && out_item_o.value_byte == '0)
    else $error("load failure item carries nonzero fields");

endmodule

bind json_trie_key_value_extractor jtkv_checker u_jtkv_checker (.*);
